[rtl/pgd_pkg.sv]
// shared types, widths, register codes and reset values of the gutter detector
package pgd_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_HEIGHT_CAP = 4096;

   localparam int PIXEL_W     = 8;
   localparam int OFFSET_W    = 12;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int LEVEL_W     = 8;
   localparam int SKIP_W      = 8;
   localparam int TOP_W       = 12;
   localparam int MARGIN_W    = 8;
   localparam int RUNLIM_W    = 4;
   localparam int RUN_W       = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int FIFO_DEPTH  = 4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WHITE_LEVEL    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SKIP_AMOUNT    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOP_LIMIT      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_BOTTOM_MARGIN  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_DARK_RUN_LIMIT = 3'd6;

   // register reset values
   localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT   = 13'd480;
   localparam logic [LEVEL_W-1:0]      RST_WHITE_LEVEL    = 8'd200;
   localparam logic [SKIP_W-1:0]       RST_SKIP_AMOUNT    = 8'd80;
   localparam logic [TOP_W-1:0]        RST_TOP_LIMIT      = 12'd150;
   localparam logic [MARGIN_W-1:0]     RST_BOTTOM_MARGIN  = 8'd30;
   localparam logic [RUNLIM_W-1:0]     RST_DARK_RUN_LIMIT = 4'd9;

   localparam logic [RUN_W-1:0] RUN_MAX = 4'hF;

   // per-pixel classification handed from front to back
   typedef struct packed {
      logic first;      // first pixel of a frame, row 0 result
      logic white;      // pixel at or above the white level
      logic ignore;     // row inside the bottom margin
      logic top_fail;   // row beyond the top limit
      logic row_emit;   // row gutter found at this pixel
      logic frame_end;  // last pixel of the frame
   } pgd_flags_type;

   // one column's state word
   typedef struct packed {
      logic             fail;
      logic [RUN_W-1:0] run;
   } pgd_entry_type;

   localparam int ENTRY_W = $bits(pgd_entry_type);
   localparam int FLAGS_W = $bits(pgd_flags_type);

endpackage

[rtl/pgd_ram.sv]
// generic single write, single read RAM with registered read data
module pgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/pgd_fifo.sv]
// short command queue between the pixel front end and the column back end
module pgd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CW'(DEPTH)) && !(pop && empty))
      else $error("queue count out of range or read while empty");

endmodule

[rtl/pgd_front.sv]
// pixel front end: raster positions, row gutter tracking, per-pixel classification
module pgd_front
   import pgd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int HEIGHT_CAP = DEF_HEIGHT_CAP
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pix_valid,
   output logic                            pix_ready,
   input  logic [PIXEL_W-1:0]              pixel,
   input  logic                            queue_full,
   input  logic                            init_busy,
   input  logic [$clog2(MAX_WIDTH):0]      width_eff,
   input  logic [$clog2(HEIGHT_CAP):0]     height_eff,
   input  logic [LEVEL_W-1:0]              white_level,
   input  logic [SKIP_W-1:0]               skip_amount,
   input  logic [TOP_W-1:0]                top_limit,
   input  logic [MARGIN_W-1:0]             bottom_margin,
   output logic                            cmd_push,
   output logic [$clog2(MAX_WIDTH)-1:0]    cmd_col,
   output logic [OFFSET_W-1:0]             cmd_row,
   output pgd_flags_type                   cmd_flags
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int CWW = CLW + 1;
   localparam int RW  = $clog2(HEIGHT_CAP);
   localparam int HWW = RW + 1;
   localparam int MW  = ((HWW > MARGIN_W) ? HWW : MARGIN_W) + 1;
   localparam int TW  = (RW > TOP_W) ? RW : TOP_W;

   logic [CLW-1:0]    col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              all_white_ff, all_white_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;

   logic           white, line_white, row_end, frame_end, in_margin, past_top;
   logic [CWW-1:0] col_next;
   logic [HWW-1:0] row_next;

   assign pix_ready = !queue_full && !init_busy;
   assign cmd_push  = pix_valid && pix_ready;

   always_comb begin
      white      = (pixel >= white_level);
      line_white = all_white_ff && white;
      col_next   = CWW'(col_ff) + 1'b1;
      row_next   = HWW'(row_ff) + 1'b1;
      row_end    = (col_next >= width_eff);
      frame_end  = row_end && (row_next >= height_eff);
      in_margin  = (MW'(row_ff) + MW'(bottom_margin)) > MW'(height_eff);
      past_top   = TW'(row_ff) > TW'(top_limit);

      cmd_col             = col_ff;
      cmd_row             = OFFSET_W'(row_ff);
      cmd_flags.first     = (col_ff == '0) && (row_ff == '0);
      cmd_flags.white     = white;
      cmd_flags.ignore    = in_margin;
      cmd_flags.top_fail  = past_top;
      cmd_flags.row_emit  = row_end && (skip_ff == '0) && line_white;
      cmd_flags.frame_end = frame_end;

      col_in       = col_ff;
      row_in       = row_ff;
      all_white_in = all_white_ff;
      skip_in      = skip_ff;
      if (cmd_push) begin
         if (row_end) begin
            if (skip_ff != '0) begin
               skip_in = skip_ff - 1'b1;
            end else if (line_white) begin
               skip_in = skip_amount;
            end
            all_white_in = 1'b1;
            col_in       = '0;
            if (frame_end) begin
               row_in  = '0;
               skip_in = '0;
            end else begin
               row_in = row_next[RW-1:0];
            end
         end else begin
            col_in       = col_next[CLW-1:0];
            all_white_in = line_white;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         all_white_ff <= 1'b1;
         skip_ff      <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         all_white_ff <= all_white_in;
         skip_ff      <= skip_in;
      end
   end

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && frame_end) |=> (col_ff == '0) && (row_ff == '0) && (skip_ff == '0)
         && all_white_ff)
      else $error("frame end did not return positions to the origin");

endmodule

[rtl/pgd_back.sv]
// column back end: column state read-modify-write, result sequencing, frame-end drain
module pgd_back
   import pgd_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   input  logic [$clog2(MAX_WIDTH)-1:0]  cmd_col,
   input  logic [OFFSET_W-1:0]           cmd_row,
   input  pgd_flags_type                 cmd_flags,
   input  logic [$clog2(MAX_WIDTH):0]    width_eff,
   input  logic [SKIP_W-1:0]             skip_amount,
   input  logic [RUNLIM_W-1:0]           dark_run_limit,
   output logic                          init_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OFFSET_W-1:0]           rsp_offset,
   output logic                          rsp_axis,
   output logic                          rsp_last
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int CWW = CLW + 1;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_FIRST = 3'd3;
   localparam logic [2:0] S_ROW   = 3'd4;
   localparam logic [2:0] S_DRD   = 3'd5;
   localparam logic [2:0] S_DCHK  = 3'd6;
   localparam logic [2:0] S_DLAST = 3'd7;

   localparam logic AXIS_ROW = 1'b0;
   localparam logic AXIS_COL = 1'b1;

   logic [2:0]          state_ff, state_in;
   logic [CLW-1:0]      addr_ff, addr_in;
   logic [CLW-1:0]      pend_ff, pend_in;
   logic [SKIP_W-1:0]   dskip_ff, dskip_in;
   logic [CLW-1:0]      col_ff, col_in;
   logic [OFFSET_W-1:0] row_ff, row_in;
   pgd_flags_type       flags_ff, flags_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                rsp_axis_ff, rsp_axis_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                ram_we, ram_re;
   logic [CLW-1:0]      ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
   pgd_entry_type       cur, nxt;

   logic                slot_free, load, start_drain, in_width, hit;
   logic [OFFSET_W-1:0] ld_offset;
   logic                ld_axis, ld_last;

   pgd_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_WIDTH)
   ) u_col_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // column rule
   always_comb begin
      cur = pgd_entry_type'(ram_rdata);
      nxt = cur;
      if (!cur.fail) begin
         if (flags_ff.white) begin
            nxt.run = '0;
         end else if (flags_ff.ignore) begin
            nxt = cur;
         end else if (flags_ff.top_fail || (cur.run > dark_run_limit)) begin
            nxt.fail = 1'b1;
         end else if (cur.run != RUN_MAX) begin
            nxt.run = cur.run + 1'b1;
         end
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign in_width  = CWW'(addr_ff) < width_eff;
   assign hit       = in_width && (dskip_ff == '0) && !cur.fail;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      pend_in     = pend_ff;
      dskip_in    = dskip_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      flags_in    = flags_ff;
      cmd_pop     = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = addr_ff;
      ram_wdata   = '0;
      ram_re      = 1'b0;
      ram_raddr   = addr_ff;
      load        = 1'b0;
      ld_offset   = '0;
      ld_axis     = AXIS_ROW;
      ld_last     = 1'b0;
      start_drain = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            if (addr_ff == CLW'(MAX_WIDTH - 1)) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               ram_re    = 1'b1;
               ram_raddr = cmd_col;
               col_in    = cmd_col;
               row_in    = cmd_row;
               flags_in  = cmd_flags;
               state_in  = S_MOD;
            end
         end
         S_MOD: begin
            ram_we    = 1'b1;
            ram_waddr = col_ff;
            ram_wdata = ENTRY_W'(nxt);
            if (flags_ff.first) begin
               state_in = S_FIRST;
            end else if (flags_ff.row_emit) begin
               state_in = S_ROW;
            end else if (flags_ff.frame_end) begin
               start_drain = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FIRST: begin
            if (slot_free) begin
               load = 1'b1;
               if (flags_ff.row_emit) begin
                  state_in = S_ROW;
               end else if (flags_ff.frame_end) begin
                  start_drain = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ROW: begin
            if (slot_free) begin
               load      = 1'b1;
               ld_offset = row_ff;
               if (flags_ff.frame_end) begin
                  start_drain = 1'b1;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DRD: begin
            ram_re   = 1'b1;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (!hit || slot_free) begin
               // clear the entry for the next frame
               ram_we = 1'b1;
               if (hit) begin
                  load      = 1'b1;
                  ld_offset = OFFSET_W'(pend_ff);
                  ld_axis   = AXIS_COL;
                  pend_in   = addr_ff;
                  dskip_in  = skip_amount;
               end else if (in_width && (dskip_ff != '0)) begin
                  dskip_in = dskip_ff - 1'b1;
               end
               if (addr_ff == CLW'(MAX_WIDTH - 1)) begin
                  state_in = S_DLAST;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         S_DLAST: begin
            if (slot_free) begin
               load      = 1'b1;
               ld_offset = OFFSET_W'(pend_ff);
               ld_axis   = AXIS_COL;
               ld_last   = 1'b1;
               addr_in   = '0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // column 0 always leads the column results
      if (start_drain) begin
         state_in = S_DRD;
         addr_in  = '0;
         pend_in  = '0;
         dskip_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_axis_in   = rsp_axis_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_offset_in = ld_offset;
         rsp_axis_in   = ld_axis;
         rsp_last_in   = ld_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      dskip_ff      <= dskip_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      flags_ff      <= flags_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_axis_ff   <= rsp_axis_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign init_busy  = (state_ff == S_INIT);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_axis   = rsp_axis_ff;
   assign rsp_last   = rsp_last_ff;

   a_quiet_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INIT) |-> !rsp_valid_ff && !cmd_pop)
      else $error("activity during the column clearing pass");

   a_drain_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLAST && slot_free) |=> rsp_valid_ff && rsp_last_ff
         && rsp_axis_ff && (state_ff == S_IDLE))
      else $error("drain did not end with a marked column result");

   a_last_is_column: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_axis_ff == AXIS_COL))
      else $error("end-of-frame mark on a row result");

endmodule

[rtl/panel_gutter_detector.sv]
// top level of the comic panel gutter detector: config registers, front, queue, back
//
//  channel  | direction | transfer when          | content
//  ---------+-----------+------------------------+-------------------------------------
//  req_     | in        | req_tvalid & req_tready | tdata: pixel
//  rsp_     | out       | rsp_tvalid & rsp_tready | tdata: offset, tuser: axis, tlast: last
//  csr_     | in        | csr_valid & csr_ready   | csr_addr register index, csr_data value
//
// a pixel passes through the back end as a read of the column state RAM and then its write-back,
// plus a state (S_FIRST or S_ROW) for each row result it loads
// at frame end the drain sweeps all MAX_WIDTH columns, reading then checking each, clearing them as it goes
// after reset a clearing pass over all MAX_WIDTH columns runs before the first pixel is taken
// the front keeps taking pixels while the 4-deep queue has room; a stalled rsp_ side
// backs up through the back end and queue to req_tready, config writes are always taken
module panel_gutter_detector
   import pgd_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int HEIGHT_CAP = DEF_HEIGHT_CAP
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] pixel
   // gutter results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [11:0] offset, [15:12] zero
   output logic                   rsp_tuser,   // [0] axis
   output logic                   rsp_tlast,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CLW = $clog2(MAX_WIDTH);
   localparam int CWW = CLW + 1;
   localparam int RW  = $clog2(HEIGHT_CAP);
   localparam int HWW = RW + 1;
   localparam int WXW = (WIDTH_REG_W > CWW) ? WIDTH_REG_W : CWW;
   localparam int HXW = (HEIGHT_REG_W > HWW) ? HEIGHT_REG_W : HWW;
   localparam int QW  = CLW + OFFSET_W + FLAGS_W;

   // configuration registers
   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic [LEVEL_W-1:0]      white_level_ff;
   logic [SKIP_W-1:0]       skip_amount_ff;
   logic [TOP_W-1:0]        top_limit_ff;
   logic [MARGIN_W-1:0]     bottom_margin_ff;
   logic [RUNLIM_W-1:0]     dark_run_limit_ff;

   logic [CWW-1:0] width_eff;
   logic [HWW-1:0] height_eff;

   logic                front_push, queue_full, queue_empty, back_pop, init_busy;
   logic [CLW-1:0]      front_col, back_col;
   logic [OFFSET_W-1:0] front_row, back_row;
   pgd_flags_type       front_flags, back_flags;
   logic [QW-1:0]       queue_in, queue_out;
   logic [OFFSET_W-1:0] rsp_offset;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RST_IMAGE_WIDTH;
         image_height_ff   <= RST_IMAGE_HEIGHT;
         white_level_ff    <= RST_WHITE_LEVEL;
         skip_amount_ff    <= RST_SKIP_AMOUNT;
         top_limit_ff      <= RST_TOP_LIMIT;
         bottom_margin_ff  <= RST_BOTTOM_MARGIN;
         dark_run_limit_ff <= RST_DARK_RUN_LIMIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data[HEIGHT_REG_W-1:0];
            CSR_WHITE_LEVEL:    white_level_ff    <= csr_data[LEVEL_W-1:0];
            CSR_SKIP_AMOUNT:    skip_amount_ff    <= csr_data[SKIP_W-1:0];
            CSR_TOP_LIMIT:      top_limit_ff      <= csr_data[TOP_W-1:0];
            CSR_BOTTOM_MARGIN:  bottom_margin_ff  <= csr_data[MARGIN_W-1:0];
            CSR_DARK_RUN_LIMIT: dark_run_limit_ff <= csr_data[RUNLIM_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // width and height clamped to 1 .. maximum
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = CWW'(1);
      end else if (WXW'(image_width_ff) > WXW'(MAX_WIDTH)) begin
         width_eff = CWW'(MAX_WIDTH);
      end else begin
         width_eff = CWW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_eff = HWW'(1);
      end else if (HXW'(image_height_ff) > HXW'(HEIGHT_CAP)) begin
         height_eff = HWW'(HEIGHT_CAP);
      end else begin
         height_eff = HWW'(image_height_ff);
      end
   end

   pgd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .HEIGHT_CAP(HEIGHT_CAP)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .pix_valid    (req_tvalid),
      .pix_ready    (req_tready),
      .pixel        (req_tdata[PIXEL_W-1:0]),
      .queue_full   (queue_full),
      .init_busy    (init_busy),
      .width_eff    (width_eff),
      .height_eff   (height_eff),
      .white_level  (white_level_ff),
      .skip_amount  (skip_amount_ff),
      .top_limit    (top_limit_ff),
      .bottom_margin(bottom_margin_ff),
      .cmd_push     (front_push),
      .cmd_col      (front_col),
      .cmd_row      (front_row),
      .cmd_flags    (front_flags)
   );

   // command word: flags, row, column from the top down
   assign queue_in = {front_flags, front_row, front_col};

   pgd_fifo #(
      .WIDTH(QW),
      .DEPTH(FIFO_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(queue_in),
      .pop      (back_pop),
      .pop_data (queue_out),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   assign back_col   = queue_out[CLW-1:0];
   assign back_row   = queue_out[CLW+OFFSET_W-1:CLW];
   assign back_flags = pgd_flags_type'(queue_out[QW-1:CLW+OFFSET_W]);

   pgd_back #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (queue_empty),
      .cmd_pop       (back_pop),
      .cmd_col       (back_col),
      .cmd_row       (back_row),
      .cmd_flags     (back_flags),
      .width_eff     (width_eff),
      .skip_amount   (skip_amount_ff),
      .dark_run_limit(dark_run_limit_ff),
      .init_busy     (init_busy),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_offset    (rsp_offset),
      .rsp_axis      (rsp_tuser),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_offset);

endmodule

[tb/gutter_checker.sv]
// gutter checker: watches the pixel, result and register channels, predicts and compares
`timescale 1ns / 1ps

module gutter_checker
   import pgd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     result_count,
   output int                     frame_count
);

   localparam logic AXIS_ROW = 1'b0;
   localparam logic AXIS_COL = 1'b1;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset;
      logic                axis;
      logic                last;
   } gutter_type;

   gutter_type expected_gutters[$];

   // register copy
   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;
   logic [LEVEL_W-1:0]      cfg_white;
   logic [SKIP_W-1:0]       cfg_skip;
   logic [TOP_W-1:0]        cfg_top;
   logic [MARGIN_W-1:0]     cfg_margin;
   logic [RUNLIM_W-1:0]     cfg_runlim;

   // frame state
   logic [9:0]          col_pos;
   logic [11:0]         row_pos;
   logic                row_white;
   logic [SKIP_W-1:0]   row_skip;
   logic [RUN_W-1:0]    col_run [DEF_MAX_WIDTH];
   logic                col_fail [DEF_MAX_WIDTH];

   function automatic gutter_type make_gutter(input int offset, input logic axis,
                                              input logic last);
      gutter_type g;
      g.offset = offset[OFFSET_W-1:0];
      g.axis   = axis;
      g.last   = last;
      return g;
   endfunction

   // append one result to the tail of the expected list
   task automatic expect_gutter(input gutter_type g);
      expected_gutters = {expected_gutters, g};
   endtask

   task automatic clear_frame_state();
      col_pos   = '0;
      row_pos   = '0;
      row_white = 1'b1;
      row_skip  = '0;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
         col_run[i]  = '0;
         col_fail[i] = 1'b0;
      end
   endtask

   // one pixel through the gutter rules, queueing every result it causes
   task automatic scan_pixel(input logic [PIXEL_W-1:0] px);
      int      w;
      int      h;
      int      col;
      int      row;
      int      j;
      logic    white;
      w = cfg_width;
      h = cfg_height;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > DEF_HEIGHT_CAP) h = DEF_HEIGHT_CAP;
      col = col_pos;
      row = row_pos;
      white = (px >= cfg_white);

      if (col == 0 && row == 0) expect_gutter(make_gutter(0, AXIS_ROW, 1'b0));
      if (!white) row_white = 1'b0;

      if (!col_fail[col]) begin
         if (white) begin
            col_run[col] = '0;
         end else if (row <= h - int'(cfg_margin)) begin
            if (row > int'(cfg_top) || col_run[col] > cfg_runlim) begin
               col_fail[col] = 1'b1;
            end else if (col_run[col] != RUN_MAX) begin
               col_run[col] = col_run[col] + 1'b1;
            end
         end
      end

      if (col + 1 >= w) begin
         if (row_skip > 0) begin
            row_skip = row_skip - 1'b1;
         end else if (row_white) begin
            expect_gutter(make_gutter(row, AXIS_ROW, 1'b0));
            row_skip = cfg_skip;
         end
         row_white = 1'b1;
         col_pos = '0;
         if (row + 1 >= h) begin
            // frame end: column 0 always, then the surviving columns with skipping
            expect_gutter(make_gutter(0, AXIS_COL, 1'b0));
            j = 0;
            while (j < w) begin
               if (!col_fail[j]) begin
                  expect_gutter(make_gutter(j, AXIS_COL, 1'b0));
                  j = j + int'(cfg_skip) + 1;
               end else begin
                  j++;
               end
            end
            expected_gutters[expected_gutters.size() - 1].last = 1'b1;
            frame_count++;
            clear_frame_state();
         end else begin
            row_pos = 12'(row + 1);
         end
      end else begin
         col_pos = 10'(col + 1);
      end
   endtask

   always @(posedge clock) begin
      gutter_type             want;
      logic [RSP_TDATA_W-1:0] want_tdata;
      if (reset) begin
         cfg_width  = RST_IMAGE_WIDTH;
         cfg_height = RST_IMAGE_HEIGHT;
         cfg_white  = RST_WHITE_LEVEL;
         cfg_skip   = RST_SKIP_AMOUNT;
         cfg_top    = RST_TOP_LIMIT;
         cfg_margin = RST_BOTTOM_MARGIN;
         cfg_runlim = RST_DARK_RUN_LIMIT;
         clear_frame_state();
         expected_gutters.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_IMAGE_WIDTH:    cfg_width  = csr_data[WIDTH_REG_W-1:0];
               CSR_IMAGE_HEIGHT:   cfg_height = csr_data[HEIGHT_REG_W-1:0];
               CSR_WHITE_LEVEL:    cfg_white  = csr_data[LEVEL_W-1:0];
               CSR_SKIP_AMOUNT:    cfg_skip   = csr_data[SKIP_W-1:0];
               CSR_TOP_LIMIT:      cfg_top    = csr_data[TOP_W-1:0];
               CSR_BOTTOM_MARGIN:  cfg_margin = csr_data[MARGIN_W-1:0];
               CSR_DARK_RUN_LIMIT: cfg_runlim = csr_data[RUNLIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) scan_pixel(req_tdata[PIXEL_W-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_gutters.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, got offset %0d axis %0d last %0d",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_gutters.pop_front();
               want_tdata = RSP_TDATA_W'(want.offset);
               if (rsp_tdata !== want_tdata) begin
                  fail_count++;
                  $display("%0t: offset mismatch: expected %0d, got %0d",
                           $time, want_tdata, rsp_tdata);
               end
               if (rsp_tuser !== want.axis) begin
                  fail_count++;
                  $display("%0t: axis mismatch at offset %0d: expected %0d, got %0d",
                           $time, want.offset, want.axis, rsp_tuser);
               end
               if (rsp_tlast !== want.last) begin
                  fail_count++;
                  $display("%0t: last mismatch at offset %0d: expected %0d, got %0d",
                           $time, want.offset, want.last, rsp_tlast);
               end
            end
         end
      end
      pending_count = expected_gutters.size();
   end

endmodule

[tb/testbench.sv]
// top of the gutter detector bench: clock, reset, pixel and register stimulus, verdict
`timescale 1ns / 1ps

module testbench;
   import pgd_pkg::*;

   // the drain walks every column, so give it time for that plus some slack
   localparam int SETTLE_CYCLES = 2 * DEF_MAX_WIDTH + 64;
   // receiver hold-off for the back-pressure phase
   localparam int HOLD_CYCLES   = 300;
   // random pixel budget
   localparam int RANDOM_PIXELS = 180;
   // hard stop, several times the slowest legal run
   localparam int LIMIT_NS      = 20_000_000;

   typedef enum {STYLE_NOISE, STYLE_PANELS, STYLE_WHITE} frame_style_type;

   typedef struct {
      int width;
      int height;
      int white;
      int skip;
      int top;
      int margin;
      int runlim;
   } panel_setup_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;    // [7:0] pixel
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // [11:0] offset, [15:12] zero
   logic                   rsp_tuser;    // [0] axis
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_data;

   int fail_count;
   int pending_count;
   int result_count;
   int frame_count;

   panel_setup_type cur;           // settings currently loaded
   bit           calm_mode;        // no idling on either side while set
   bit           hold_request;     // asks the receiver for one long hold-off
   bit           col_gutter [DEF_MAX_WIDTH];
   int           pixel_total;
   int           setup_total;

   panel_gutter_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   gutter_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_addr      (csr_addr),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .frame_count   (frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #LIMIT_NS;
      $display("Verification failed");
      $finish;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_mode || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] light_pixel();
      return 8'($urandom_range(cur.white, 255));
   endfunction

   function automatic logic [7:0] dark_pixel();
      if (cur.white == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, cur.white - 1));
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            g = idle_gap();
            if (g > 0) begin
               rsp_tready <= 1'b0;
               repeat (g) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   // one pixel transfer; valid stays up afterwards so the next pixel can follow directly
   task automatic send_pixel(input logic [7:0] px);
      int g;
      g = idle_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pixel_total++;
   endtask

   // a whole frame at the current settings
   task automatic send_frame(input frame_style_type style);
      int         w;
      int         h;
      bit         row_gutter;
      logic [7:0] px;
      w = cur.width;
      h = cur.height;
      if (w < 1) w = 1;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
      if (h < 1) h = 1;
      if (h > DEF_HEIGHT_CAP) h = DEF_HEIGHT_CAP;
      for (int c = 0; c < w; c++) col_gutter[c] = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < h; r++) begin
         row_gutter = ($urandom_range(0, 4) == 0);
         for (int c = 0; c < w; c++) begin
            case (style)
               STYLE_NOISE: px = 8'($urandom_range(0, 255));
               STYLE_WHITE: px = light_pixel();
               default: begin
                  // gutters white, panel interiors mostly dark
                  if (row_gutter || col_gutter[c] || $urandom_range(0, 9) >= 7)
                     px = light_pixel();
                  else
                     px = dark_pixel();
               end
            endcase
            send_pixel(px);
         end
      end
   endtask

   // load all registers; only once the block has drained and gone quiet
   task automatic apply_setup(input panel_setup_type s);
      logic [CSR_ADDR_W-1:0] idx [7];
      int                    val [7];
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      idx[0] = CSR_IMAGE_WIDTH;    val[0] = s.width;
      idx[1] = CSR_IMAGE_HEIGHT;   val[1] = s.height;
      idx[2] = CSR_WHITE_LEVEL;    val[2] = s.white;
      idx[3] = CSR_SKIP_AMOUNT;    val[3] = s.skip;
      idx[4] = CSR_TOP_LIMIT;      val[4] = s.top;
      idx[5] = CSR_BOTTOM_MARGIN;  val[5] = s.margin;
      idx[6] = CSR_DARK_RUN_LIMIT; val[6] = s.runlim;
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_addr  <= idx[i];
         csr_data  <= CSR_DATA_W'(val[i]);
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      cur = s;
      setup_total++;
   endtask

   initial begin
      logic [7:0]      single_pixels [8];
      logic [7:0]      small_frame [12];
      panel_setup_type s;
      int              random_pixels;
      int              shape;
      int              frames;

      // every input known from time zero
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_addr     = '0;
      csr_data     = '0;
      calm_mode    = 1'b0;
      hold_request = 1'b0;
      pixel_total  = 0;
      setup_total  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: width and height of zero act as one, so every pixel is a whole frame;
      // no skipping, pixel extremes and both sides of the white level
      apply_setup('{0, 0, 200, 0, 4095, 0, 0});
      single_pixels = '{8'd0, 8'd255, 8'd199, 8'd200, 8'd201, 8'd128, 8'd1, 8'd254};
      foreach (single_pixels[i]) send_pixel(single_pixels[i]);

      // directed: tiny frame with a run failure, a top limit failure, a bottom margin
      // pixel and a white last row, so the row result precedes the column results
      apply_setup('{3, 4, 128, 0, 1, 2, 0});
      small_frame = '{8'd255, 8'd0,   8'd127,
                      8'd128, 8'd0,   8'd200,
                      8'd200, 8'd255, 8'd0,
                      8'd130, 8'd131, 8'd129};
      foreach (small_frame[i]) send_pixel(small_frame[i]);

      // back-pressure: every row is a gutter, receiver holds off while pixels keep coming
      apply_setup('{2, 40, 100, 0, 4095, 0, 15});
      hold_request = 1'b1;
      send_frame(STYLE_WHITE);

      // margin covering the whole frame, run limit at the saturation point
      apply_setup('{5, 6, 255, 0, 0, 255, 15});
      send_frame(STYLE_NOISE);

      // random settings, each held for one or two frames
      random_pixels = pixel_total;
      while (pixel_total - random_pixels < RANDOM_PIXELS) begin
         shape = $urandom_range(0, 9);
         if (shape < 6) begin
            s.width  = $urandom_range(1, 16);
            s.height = $urandom_range(2, 10);
         end else if (shape < 8) begin
            s.width  = $urandom_range(33, 70);
            s.height = $urandom_range(2, 3);
         end else begin
            s.width  = $urandom_range(1, 2);
            s.height = $urandom_range(34, 70);
         end
         case ($urandom_range(0, 9))
            0:       s.white = 0;
            1:       s.white = 255;
            default: s.white = $urandom_range(40, 220);
         endcase
         case ($urandom_range(0, 9))
            0, 1, 2: s.skip = 0;
            3:       s.skip = 255;
            default: s.skip = $urandom_range(32, 60);
         endcase
         case ($urandom_range(0, 9))
            0:       s.top = 0;
            1:       s.top = 4095;
            default: s.top = $urandom_range(0, s.height);
         endcase
         case ($urandom_range(0, 9))
            0:       s.margin = 0;
            1:       s.margin = 255;
            default: s.margin = $urandom_range(0, s.height);
         endcase
         s.runlim = $urandom_range(0, 15);
         apply_setup(s);
         calm_mode = ($urandom_range(0, 4) == 0);
         frames = $urandom_range(1, 2);
         repeat (frames) begin
            case ($urandom_range(0, 9))
               0, 1:    send_frame(STYLE_NOISE);
               2, 3:    send_frame(STYLE_WHITE);
               default: send_frame(STYLE_PANELS);
            endcase
         end
         calm_mode = 1'b0;
      end

      // drain: nothing left expected, then let the column sweep finish
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("covered %0d pixels in %0d frames over %0d register settings",
               pixel_total, frame_count, setup_total);
      $display("checked %0d gutter results, with one long receiver hold-off and one-pixel frames",
               result_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
